// ===== rtl/gvc_pkg.sv =====
// Shared types, widths and colour constants for the gauge value to GRB colour block.
// No dependencies.
package gvc_pkg;

  localparam int VAL_W    = 16;
  localparam int NUM_W    = 24;
  localparam int DIV_W    = 17;
  localparam int QUO_W    = 8;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN      = 4'd1;

  localparam logic [VAL_W-1:0] SPAN_RESET = 16'd1000;

  localparam logic [1:0] KIND_OFF  = 2'd0;
  localparam logic [1:0] KIND_CRIT = 2'd1;
  localparam logic [1:0] KIND_HIGH = 2'd2;
  localparam logic [1:0] KIND_GRAD = 2'd3;

  // low colour green weight and green step to the high colour
  localparam logic [7:0] LOW_G_W   = 8'd80;
  localparam logic [7:0] STEP_G_W  = 8'd175;
  localparam logic [7:0] LOW_R_W   = 8'd255;
  localparam logic [7:0] LEVEL_MAX = 8'd255;

  typedef struct packed {
    logic [VAL_W-1:0] sample_value;
    logic             led_enabled;
  } gvc_in_t;

  typedef struct packed {
    logic [7:0] green_level;
    logic [7:0] red_level;
    logic [7:0] blue_level;
  } gvc_out_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [DIV_W-1:0] div;
    logic [NUM_W-1:0] rem_g;
    logic [NUM_W-1:0] rem_r;
    logic [QUO_W-1:0] q_g;
    logic [QUO_W-1:0] q_r;
  } gvc_lane_t;

endpackage

// ===== rtl/gvc_front.sv =====
// Entry stage: classifies the item and forms both numerators and the divisor.
// Depends on gvc_pkg.
module gvc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     take,
  input  gvc_pkg::gvc_in_t         item,
  input  logic [gvc_pkg::VAL_W-1:0] threshold,
  input  logic [gvc_pkg::VAL_W-1:0] span,
  output logic                     vld_o,
  output gvc_pkg::gvc_lane_t       lane_o
);
  import gvc_pkg::*;

  logic             vld_r;
  gvc_lane_t        lane_r;
  gvc_lane_t        lane_nxt;
  logic [VAL_W-1:0] t;

  always_comb begin
    t                 = item.sample_value - threshold;
    lane_nxt.div      = {1'b0, span} + DIV_W'(1);
    lane_nxt.rem_g    = NUM_W'(LOW_G_W) * NUM_W'(span) + NUM_W'(STEP_G_W) * NUM_W'(t);
    lane_nxt.rem_r    = NUM_W'(LOW_R_W) * NUM_W'(span - t);
    lane_nxt.q_g      = '0;
    lane_nxt.q_r      = '0;
    if (!item.led_enabled) begin
      lane_nxt.kind = KIND_OFF;
    end else if (item.sample_value < threshold) begin
      lane_nxt.kind = KIND_CRIT;
    end else if (t >= span) begin
      lane_nxt.kind = KIND_HIGH;
    end else begin
      lane_nxt.kind = KIND_GRAD;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= take;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;

endmodule

// ===== rtl/gvc_div_cell.sv =====
// One restoring division step for both gradient channels, registered.
// Depends on gvc_pkg.
module gvc_div_cell #(
  parameter int STEP = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  gvc_pkg::gvc_lane_t lane_i,
  output logic               vld_o,
  output gvc_pkg::gvc_lane_t lane_o
);
  import gvc_pkg::*;

  logic             vld_r;
  gvc_lane_t        lane_r;
  gvc_lane_t        lane_nxt;
  logic [NUM_W-1:0] dsh;
  logic             ge_g;
  logic             ge_r;

  always_comb begin
    dsh      = NUM_W'(lane_i.div) << STEP;
    ge_g     = lane_i.rem_g >= dsh;
    ge_r     = lane_i.rem_r >= dsh;
    lane_nxt = lane_i;
    lane_nxt.rem_g = ge_g ? lane_i.rem_g - dsh : lane_i.rem_g;
    lane_nxt.rem_r = ge_r ? lane_i.rem_r - dsh : lane_i.rem_r;
    lane_nxt.q_g   = {lane_i.q_g[QUO_W-2:0], ge_g};
    lane_nxt.q_r   = {lane_i.q_r[QUO_W-2:0], ge_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign vld_o  = vld_r;
  assign lane_o = lane_r;

endmodule

// ===== rtl/gauge_value_to_grb_color_top.sv =====
// Top level of the gauge value to GRB colour block: config registers, division chain, output.
// Depends on gvc_pkg, gvc_front and gvc_div_cell.
//
// One item is taken every clock cycle; busy is always low. Each result appears on out_data
// with out_valid high for one cycle, once its item has passed through the registers of one entry
// stage, eight division cells (one quotient bit each, divisor span+1) and the output
// register. Results come out in input order and must be taken as they appear, since the
// receiver cannot stall. cfg_ready is always high; write configuration while no item is
// in flight.
module gauge_value_to_grb_color_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  gvc_pkg::gvc_in_t              in_data,
  output logic                          out_valid,
  output gvc_pkg::gvc_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gvc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gvc_pkg::CFG_DAT_W-1:0] cfg_data
);
  import gvc_pkg::*;

  logic [VAL_W-1:0] threshold_r;
  logic [VAL_W-1:0] span_r;
  logic             out_valid_r;
  gvc_out_t         out_data_r;
  gvc_out_t         out_data_nxt;

  logic      chain_vld  [QUO_W+1];
  gvc_lane_t chain_lane [QUO_W+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= '0;
      span_r      <= SPAN_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_THRESHOLD) begin
        threshold_r <= cfg_data;
      end else if (cfg_index == CFG_SPAN) begin
        span_r <= cfg_data;
      end
    end
  end

  gvc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (start && !busy),
    .item      (in_data),
    .threshold (threshold_r),
    .span      (span_r),
    .vld_o     (chain_vld[0]),
    .lane_o    (chain_lane[0])
  );

  // cell i resolves quotient bit QUO_W-1-i
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    gvc_div_cell #(
      .STEP (QUO_W - 1 - i)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (chain_vld[i]),
      .lane_i (chain_lane[i]),
      .vld_o  (chain_vld[i+1]),
      .lane_o (chain_lane[i+1])
    );
  end

  always_comb begin
    unique case (chain_lane[QUO_W].kind)
      KIND_OFF: begin
        out_data_nxt = '{green_level: 8'd0, red_level: 8'd0, blue_level: LEVEL_MAX};
      end
      KIND_CRIT: begin
        out_data_nxt = '{green_level: 8'd0, red_level: LEVEL_MAX, blue_level: 8'd0};
      end
      KIND_HIGH: begin
        out_data_nxt = '{green_level: LEVEL_MAX, red_level: 8'd0, blue_level: 8'd0};
      end
      default: begin
        out_data_nxt = '{green_level: chain_lane[QUO_W].q_g,
                         red_level:   chain_lane[QUO_W].q_r,
                         blue_level:  8'd0};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_vld[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // remainder below divisor once all quotient bits are resolved
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    chain_vld[QUO_W] && chain_lane[QUO_W].kind == KIND_GRAD |->
      chain_lane[QUO_W].rem_g < NUM_W'(chain_lane[QUO_W].div) &&
      chain_lane[QUO_W].rem_r < NUM_W'(chain_lane[QUO_W].div))
    else $error("division remainder not below divisor");

  a_blue_only_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.blue_level != 8'd0 |->
      out_data.green_level == 8'd0 && out_data.red_level == 8'd0)
    else $error("blue mixed with other channels");

  a_full_green_high: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.green_level == LEVEL_MAX |->
      out_data.red_level == 8'd0 && out_data.blue_level == 8'd0)
    else $error("full green outside the high colour");

endmodule
